// ===== hdl/wbc_pkg.sv =====
// Shared constants, types and command codes for the word-break checker.
`default_nettype none

package wbc_pkg;

    // Dictionary geometry
    localparam int DICT_WORDS   = 16;
    localparam int MAX_WORD_LEN = 16;

    // Derived widths
    localparam int ROW_W    = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int CNT_W    = $clog2(DICT_WORDS + 1);
    localparam int POS_W    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LEN_W    = $clog2(MAX_WORD_LEN + 2);
    localparam int PREFIX_W = MAX_WORD_LEN + 1;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    // Marker for a word that ran past the maximum length
    localparam logic [LEN_W-1:0] OVERLONG = LEN_W'(MAX_WORD_LEN + 1);

    // Command codes carried in tuser
    localparam logic [1:0] CMD_DICT  = 2'd0;
    localparam logic [1:0] CMD_TEXT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [7:0] byte_t;

    // One stored word, or the text window; byte 0 is the lowest
    typedef logic [MAX_WORD_LEN-1:0][7:0] row_t;

    // Write side of the dictionary store
    typedef struct packed {
        logic  load;
        logic  clear;
        logic  last;
        byte_t ch;
    } dict_wr_t;

endpackage : wbc_pkg

`default_nettype wire

// ===== hdl/dictionary_word_break_checker_unit.sv =====
// Top level: stream ports, scan sequencer, text window and prefix bits.
// A dictionary byte or a clear command is taken while the block stays idle.
// A text byte holds the block busy through the scan and wrap states, longer if a verdict must wait:
// the sequencer reads one stored word per cycle and runs it through the compare unit.
// Only a text byte with tlast gives a verdict: the wrap state loads it into a free output register.
// Reset (rst_n low, asynchronous) empties the dictionary, zeroes the window, sets prefix bits to value 1.
`default_nettype none

module dictionary_word_break_checker_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wbc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] ch
    input  wire logic [wbc_pkg::IN_TUSER_W-1:0]  s_tuser,   // [1:0] cmd
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [wbc_pkg::OUT_TDATA_W-1:0]      m_tdata    // [0] breakable, [1] dict_overflow
);
    import wbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WRAP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    row_t               window_reg, window_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               hit_reg, hit_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_brk_reg, out_brk_next;
    logic               out_ovf_reg, out_ovf_next;

    dict_wr_t           dict_wr;
    row_t               rd_data;
    logic [LEN_W-1:0]   rd_len;
    logic [CNT_W-1:0]   word_count;
    logic               overflow;
    logic               match_hit;
    logic               accept;
    logic               issue;
    logic               out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (state_reg == S_SCAN) && (w_reg < word_count);
    assign out_free = !out_valid_reg || m_tready;

    // Dictionary side of an accepted transfer
    always_comb
    begin
        dict_wr.load  = accept && (s_tuser == CMD_DICT);
        dict_wr.clear = accept && (s_tuser == CMD_CLEAR);
        dict_wr.last  = s_tlast;
        dict_wr.ch    = s_tdata[7:0];
    end

    wbc_dict u_dict (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (dict_wr),
        .rd_en      (issue),
        .rd_row     (w_reg[ROW_W-1:0]),
        .rd_data    (rd_data),
        .rd_len     (rd_len),
        .word_count (word_count),
        .overflow   (overflow)
    );

    wbc_match u_match (
        .word   (rd_data),
        .len    (rd_len),
        .window (window_reg),
        .prefix (prefix_reg),
        .hit    (match_hit)
    );

    // Sequencer: take a text byte, scan stored words, then commit
    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        prefix_next    = prefix_reg;
        w_next         = w_reg;
        rd_valid_next  = rd_valid_reg;
        hit_next       = hit_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_brk_next   = out_brk_reg;
        out_ovf_next   = out_ovf_reg;

        // Drop the result once its transfer completes
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_tuser == CMD_TEXT))
                begin
                    window_next   = row_t'({window_reg, s_tdata[7:0]});
                    last_next     = s_tlast;
                    w_next        = '0;
                    rd_valid_next = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_valid_next = issue;
                hit_next      = hit_reg | (rd_valid_reg & match_hit);
                if (issue)
                begin
                    w_next = w_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                if (!last_reg || out_free)
                begin
                    if (last_reg)
                    begin
                        prefix_next    = PREFIX_W'(1);
                        out_valid_next = 1'b1;
                        out_brk_next   = hit_reg;
                        out_ovf_next   = overflow;
                    end
                    else
                    begin
                        prefix_next = {prefix_reg[PREFIX_W-2:0], hit_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= '0;
            prefix_reg    <= PREFIX_W'(1);
            w_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            prefix_reg    <= prefix_next;
            w_reg         <= w_next;
            rd_valid_reg  <= rd_valid_next;
            hit_reg       <= hit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_brk_reg <= out_brk_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2)'(0), out_ovf_reg, out_brk_reg};

endmodule : dictionary_word_break_checker_unit

`default_nettype wire

// ===== hdl/wbc_dict.sv =====
// Dictionary store: word rows, word lengths and the load bookkeeping.
`default_nettype none

module wbc_dict (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire wbc_pkg::dict_wr_t         wr,
    input  wire logic                      rd_en,
    input  wire logic [wbc_pkg::ROW_W-1:0] rd_row,
    output wbc_pkg::row_t                  rd_data,
    output logic [wbc_pkg::LEN_W-1:0]      rd_len,
    output logic [wbc_pkg::CNT_W-1:0]      word_count,
    output logic                           overflow
);
    import wbc_pkg::*;

    row_t              mem [DICT_WORDS];
    logic [LEN_W-1:0]  len_reg [DICT_WORDS];

    logic [CNT_W-1:0]  word_count_reg, word_count_next;
    logic [LEN_W-1:0]  load_pos_reg, load_pos_next;
    logic              overflow_reg, overflow_next;
    row_t              rd_data_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    logic              room;
    logic              pos_ok;
    logic [LEN_W-1:0]  pos_inc;
    logic              word_fits;

    // Room for one more word and one more byte
    assign room      = word_count_reg < CNT_W'(DICT_WORDS);
    assign pos_ok    = load_pos_reg < LEN_W'(MAX_WORD_LEN);
    assign pos_inc   = pos_ok ? (load_pos_reg + LEN_W'(1)) : OVERLONG;
    assign word_fits = (pos_inc <= LEN_W'(MAX_WORD_LEN)) && room;

    // Load bookkeeping: clear, or advance position and commit or drop on the last byte
    always_comb
    begin
        word_count_next = word_count_reg;
        load_pos_next   = load_pos_reg;
        overflow_next   = overflow_reg;
        if (wr.clear)
        begin
            word_count_next = '0;
            load_pos_next   = '0;
            overflow_next   = 1'b0;
        end
        else if (wr.load)
        begin
            load_pos_next = pos_inc;
            if (wr.last)
            begin
                if (word_fits)
                begin
                    word_count_next = word_count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                load_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            load_pos_reg   <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            load_pos_reg   <= load_pos_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Write a dictionary byte into its row
    always_ff @(posedge clk)
    begin
        if (wr.load && pos_ok && room)
        begin
            mem[word_count_reg[ROW_W-1:0]][load_pos_reg[POS_W-1:0]] <= wr.ch;
        end
    end

    // Record the length of a committed word
    always_ff @(posedge clk)
    begin
        if (wr.load && wr.last && word_fits)
        begin
            len_reg[word_count_reg[ROW_W-1:0]] <= pos_inc;
        end
    end

    // Registered read of one whole word row
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
            rd_len_reg  <= len_reg[rd_row];
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_len     = rd_len_reg;
    assign word_count = word_count_reg;
    assign overflow   = overflow_reg;

endmodule : wbc_dict

`default_nettype wire

// ===== hdl/wbc_match.sv =====
// Shared compare unit: does one stored word end at the newest text byte, with a segmentable prefix.
`default_nettype none

module wbc_match (
    input  wire wbc_pkg::row_t                word,
    input  wire logic [wbc_pkg::LEN_W-1:0]    len,
    input  wire wbc_pkg::row_t                window,
    input  wire logic [wbc_pkg::PREFIX_W-1:0] prefix,
    output logic                              hit
);
    import wbc_pkg::*;

    logic [LEN_W-1:0]        len_m1;
    logic [MAX_WORD_LEN-1:0] prefix_lo;
    logic                    len_ok;
    logic                    all_eq;

    assign len_m1    = len - LEN_W'(1);
    assign prefix_lo = prefix[MAX_WORD_LEN-1:0];
    assign len_ok    = (len != '0) && (len <= LEN_W'(MAX_WORD_LEN));

    // Word byte p faces the window byte len-1-p back from the newest
    always_comb
    begin
        logic [LEN_W-1:0] back;
        all_eq = 1'b1;
        back   = '0;
        for (int p = 0; p < MAX_WORD_LEN; p++)
        begin
            back = len_m1 - LEN_W'(p);
            if ((LEN_W'(p) < len) && (word[p] != window[back[POS_W-1:0]]))
            begin
                all_eq = 1'b0;
            end
        end
    end

    // Prefix before the word must itself be segmentable
    assign hit = len_ok && all_eq && prefix_lo[len_m1[POS_W-1:0]];

endmodule : wbc_match

`default_nettype wire

// ===== hdl/wbc_checker.sv =====
// Port-level checker for the word-break checker, bound to the top level.
`default_nettype none

module wbc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [wbc_pkg::IN_TUSER_W-1:0]     s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [wbc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import wbc_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A text transfer makes the block busy for the scan
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_TEXT) |=> !s_tready)
        else $error("ready during text scan");

    // A new result only comes out of a scan
    a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a scan");

    // Padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:2] == '0))
        else $error("result padding not zero");

endmodule : wbc_checker

bind dictionary_word_break_checker_unit wbc_checker u_wbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
